// ===== hw/rtl/sacc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sacc_pkg;

  // fixed field widths
  localparam int ADDR_W = 32;
  localparam int LAT_W  = 10;
  localparam int COST_W = 11;

  // lower-level write codes
  localparam logic [1:0] LW_NONE  = 2'd0;
  localparam logic [1:0] LW_BLOCK = 2'd1;
  localparam logic [1:0] LW_BYTE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WRITE_BACK     = 2'd0;
  localparam logic [1:0] CFG_WRITE_ALLOCATE = 2'd1;
  localparam logic [1:0] CFG_HIT_LATENCY    = 2'd2;
  localparam logic [1:0] CFG_MISS_LATENCY   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic lookup_rd;
    logic compare;
    logic update;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sacc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sacc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output sacc_pkg::dp_cmd_t      cmd,
  input  wire sacc_pkg::dp_sts_t sts
);

  import sacc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd.clear_wr  = (state_r == ST_CLEAR);
    cmd.capture   = (state_r == ST_IDLE) && start;
    cmd.lookup_rd = (state_r == ST_READ);
    cmd.compare   = (state_r == ST_CMP);
    cmd.update    = (state_r == ST_UPD);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/sacc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sacc_dp #(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sacc_pkg::dp_cmd_t cmd,
  output sacc_pkg::dp_sts_t      sts,
  input  wire logic              in_req_type,
  input  wire logic [31:0]       in_addr,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [9:0]        cfg_data,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [1:0]             out_way,
  output logic                   out_fill_block,
  output logic                   out_evict_dirty,
  output logic [31:0]            out_victim_block_addr,
  output logic [1:0]             out_lower_write,
  output logic [10:0]            out_cost
);

  import sacc_pkg::*;

  localparam int OB     = $clog2(BLOCK_BYTES);
  localparam int SB     = $clog2(SETS);
  localparam int TAGW   = ADDR_W - OB - SB;
  localparam int SW     = (SB > 0) ? SB : 1;
  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W = 2 + TAGW + WW;
  localparam int ROW_W  = WAYS * LINE_W;
  localparam logic [ADDR_W-1:0] SET_MASK = (ADDR_W'(1) << SB) - ADDR_W'(1);

  // configuration registers
  logic              wb_r, wa_r;
  logic [LAT_W-1:0]  hit_lat_r, miss_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r       <= 1'b1;
      wa_r       <= 1'b1;
      hit_lat_r  <= LAT_W'(1);
      miss_lat_r <= LAT_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WRITE_BACK:     wb_r       <= cfg_data[0];
        CFG_WRITE_ALLOCATE: wa_r       <= cfg_data[0];
        CFG_HIT_LATENCY:    hit_lat_r  <= cfg_data;
        CFG_MISS_LATENCY:   miss_lat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture: split address into tag and set
  logic            req_write_r;
  logic [TAGW-1:0] req_tag_r;
  logic [SW-1:0]   req_set_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_write_r <= in_req_type;
      req_tag_r   <= TAGW'(in_addr >> (OB + SB));
      req_set_r   <= SW'((in_addr >> OB) & SET_MASK);
    end
  end

  // clearing sweep over the sets after reset
  logic [SW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx_r <= clr_idx_r + SW'(1);
    end
  end

  assign sts.clear_last = (clr_idx_r == SW'(SETS - 1));

  // reset row: invalid, clean, rank equals way index
  logic [ROW_W-1:0] reset_row;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      reset_row[w*LINE_W +: LINE_W] = {WW'(w), TAGW'(0), 1'b0, 1'b0};
    end
  end

  // set row memory
  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata, row_rd, new_row;
  logic             upd_we;

  assign ram_we    = cmd.clear_wr | (cmd.update & upd_we);
  assign ram_waddr = cmd.clear_wr ? clr_idx_r : req_set_r;
  assign ram_wdata = cmd.clear_wr ? reset_row : new_row;

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.lookup_rd),
    .raddr (req_set_r),
    .rdata (row_rd)
  );

  // unpack the row into ways
  logic            ln_valid [WAYS];
  logic            ln_dirty [WAYS];
  logic [TAGW-1:0] ln_tag   [WAYS];
  logic [WW-1:0]   ln_rank  [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ln_valid[w] = row_rd[w*LINE_W];
      ln_dirty[w] = row_rd[w*LINE_W + 1];
      ln_tag[w]   = row_rd[w*LINE_W + 2 +: TAGW];
      ln_rank[w]  = row_rd[w*LINE_W + 2 + TAGW +: WW];
    end
  end

  // tag compare and victim search, lowest way wins
  logic          hit_c, inv_c;
  logic [WW-1:0] hit_way_c, inv_way_c, lru_way_c;

  always_comb begin
    hit_c     = 1'b0;
    inv_c     = 1'b0;
    hit_way_c = '0;
    inv_way_c = '0;
    lru_way_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ln_valid[w] && (ln_tag[w] == req_tag_r)) begin
        hit_c     = 1'b1;
        hit_way_c = WW'(w);
      end
      if (!ln_valid[w]) begin
        inv_c     = 1'b1;
        inv_way_c = WW'(w);
      end
      if (ln_rank[w] == WW'(WAYS - 1)) begin
        lru_way_c = WW'(w);
      end
    end
  end

  logic          hit_r;
  logic [WW-1:0] hit_way_r, vic_way_r;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      hit_r     <= hit_c;
      hit_way_r <= hit_way_c;
      vic_way_r <= inv_c ? inv_way_c : lru_way_c;
    end
  end

  // update: new row contents and result word
  logic              bypass, fill, evict;
  logic [WW-1:0]     sel_way, old_rank;
  logic [1:0]        lw;
  logic [31:0]       vaddr;
  logic [COST_W-1:0] cost_base, cost_extra;

  assign sel_way  = hit_r ? hit_way_r : vic_way_r;
  assign bypass   = !hit_r && req_write_r && !wa_r;
  assign fill     = !hit_r && !bypass;
  assign evict    = fill && wb_r && ln_valid[sel_way] && ln_dirty[sel_way];
  assign old_rank = ln_rank[sel_way];
  assign upd_we   = !bypass;

  always_comb begin
    new_row = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) == sel_way) begin
        new_row[w*LINE_W + 2 + TAGW +: WW] = '0;
        if (hit_r) begin
          new_row[w*LINE_W + 1] = ln_dirty[w] | req_write_r;
        end else begin
          new_row[w*LINE_W]              = 1'b1;
          new_row[w*LINE_W + 1]          = req_write_r;
          new_row[w*LINE_W + 2 +: TAGW]  = req_tag_r;
        end
      end else if (ln_rank[w] < old_rank) begin
        new_row[w*LINE_W + 2 + TAGW +: WW] = ln_rank[w] + WW'(1);
      end
    end
  end

  always_comb begin
    if (bypass) begin
      lw = LW_BYTE;
    end else if (req_write_r && !wb_r) begin
      lw = LW_BLOCK;
    end else begin
      lw = LW_NONE;
    end
  end

  assign vaddr = evict ? ((ADDR_W'(ln_tag[sel_way]) << (OB + SB)) |
                          (ADDR_W'(req_set_r) << OB))
                       : '0;

  assign cost_base  = COST_W'(hit_r ? hit_lat_r : miss_lat_r);
  assign cost_extra = ((lw == LW_BLOCK) || evict) ? COST_W'(miss_lat_r) : '0;

  // result register, one strobe per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit               <= hit_r;
      out_way               <= bypass ? 2'd0 : 2'(sel_way);
      out_fill_block        <= fill;
      out_evict_dirty       <= evict;
      out_victim_block_addr <= vaddr;
      out_lower_write       <= lw;
      out_cost              <= cost_base + cost_extra;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_lru_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// after the accepting edge an access steps through the tag row read, compare and update states to the result strobe
// a new access is taken only while busy is low, set by the read-modify-write of the set row memory
// the result strobe lasts one cycle; the receiver cannot stall
// reset: synchronous, active low; a clearing sweep over the sets then empties every set
// busy stays high during the sweep; configuration writes are taken at any time outside reset

module set_assoc_cache_tag_lru_controller_unit #(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_addr,
  output logic             out_valid,
  output logic             out_hit,
  output logic [1:0]       out_way,
  output logic             out_fill_block,
  output logic             out_evict_dirty,
  output logic [31:0]      out_victim_block_addr,
  output logic [1:0]       out_lower_write,
  output logic [10:0]      out_cost,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  import sacc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // registers are always writable outside reset
  assign cfg_ready = 1'b1;

  sacc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  sacc_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_req_type           (in_req_type),
    .in_addr               (in_addr),
    .cfg_valid             (cfg_valid & cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_way               (out_way),
    .out_fill_block        (out_fill_block),
    .out_evict_dirty       (out_evict_dirty),
    .out_victim_block_addr (out_victim_block_addr),
    .out_lower_write       (out_lower_write),
    .out_cost              (out_cost)
  );

`ifndef SYNTHESIS
  // accepted access keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in flight");

  // hits never fill or evict
  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_fill_block && !out_evict_dirty)
    else $error("hit reported fill or eviction");

  // victim address only with a dirty eviction
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evict_dirty |-> out_victim_block_addr == 32'd0)
    else $error("victim address without eviction");

  // forwarded byte leaves the cache untouched
  a_forward_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lower_write == LW_BYTE |->
      !out_hit && !out_fill_block && out_way == 2'd0)
    else $error("forwarded write with allocation");
`endif

endmodule

`default_nettype wire
